>>> sv/rac_pkg.sv
// Shared codes and constants for the rational accumulator ALU.
// Holds operation codes, status codes and default parameter values.
// No dependencies.
package rac_pkg;

    // Default value width for the overflow check.
    localparam int VALUE_WIDTH_DEF = 32;

    // Operation codes carried on the input beat.
    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_INC  = 3'd5;

    // Status codes returned with each result beat.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

endpackage

>>> sv/rational_accumulator_alu_core.sv
// Rational accumulator ALU: one item at a time through a shared 32x32 multiplier,
// a binary gcd loop of one subtract or shift per cycle, and a restoring divider.
// An error or unused op goes from idle straight to write-back; otherwise the multiply and combine
// states run, then the gcd loop and the divider, then write-back; a zero result skips from combine to
// write-back. The next beat is taken after write-back.
// Reset (rst_n low, asynchronous) sets the accumulator to 0/1 and empties the output.
module rational_accumulator_alu_core
    import rac_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: operand_num [31:0], operand_den [63:32].
    input  logic [63:0] s_axis_tdata,
    // Fields from bit 0: op [2:0].
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: result_num [31:0], result_den [62:32], zero pad [63].
    output logic [63:0] m_axis_tdata,
    // Fields from bit 0: status [1:0].
    output logic [1:0]  m_axis_tuser
);

    // Largest magnitude allowed for a stored denominator.
    localparam logic [63:0] LIM = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_COMB = 6'b000100,
        S_GCD  = 6'b001000,
        S_DIV  = 6'b010000,
        S_WB   = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic        store_reg, store_next;
    logic [31:0] acc_num_reg, acc_num_next;
    logic [31:0] acc_den_reg, acc_den_next;

    logic [2:0]  op_reg, op_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] am_reg, am_next;
    logic [31:0] ad_reg, ad_next;
    logic [31:0] oa_reg, oa_next;
    logic [31:0] od_reg, od_next;
    logic        an_reg, an_next;
    logic        on_reg, on_next;
    logic        rn_reg, rn_next;
    logic [63:0] p0_reg, p0_next;
    logic [63:0] p1_reg, p1_next;
    logic [63:0] p2_reg, p2_next;
    logic [63:0] ga_reg, ga_next;
    logic [63:0] gb_reg, gb_next;
    logic [63:0] qn_reg, qn_next;
    logic [63:0] qd_reg, qd_next;
    logic [63:0] rmn_reg, rmn_next;
    logic [63:0] rmd_reg, rmd_next;
    logic [63:0] g_reg, g_next;
    logic [63:0] res_reg, res_next;
    logic [31:0] on_out_reg, on_out_next;
    logic [30:0] od_out_reg, od_out_next;
    logic [1:0]  st_out_reg, st_out_next;

    // Combinational helpers.
    logic [31:0] in_num, in_den, mag_num, mag_den;
    logic [31:0] mx, my;
    logic [63:0] prod;
    logic        s0, s1;
    logic [63:0] sum_m;
    logic        sum_n;
    logic [63:0] dn_try, dd_try;
    logic        ovf;
    logic        in_fire;

    assign in_num  = s_axis_tdata[31:0];
    assign in_den  = s_axis_tdata[63:32];
    assign mag_num = in_num[31] ? (32'd0 - in_num) : in_num;
    assign mag_den = in_den[31] ? (32'd0 - in_den) : in_den;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Operand select for the shared multiplier, one product per cycle.
    always_comb
    begin
        mx = am_reg;
        my = od_reg;
        case (cnt_reg[1:0])
            2'd0:
            begin
                mx = (op_reg == OP_LOAD) ? oa_reg : am_reg;
                if (op_reg == OP_LOAD || op_reg == OP_INC)
                    my = 32'd1;
                else if (op_reg == OP_MUL)
                    my = oa_reg;
                else
                    my = od_reg;
            end
            2'd1:
            begin
                mx = (op_reg == OP_INC) ? ad_reg : oa_reg;
                my = (op_reg == OP_INC) ? 32'd1 : ad_reg;
            end
            default:
            begin
                mx = (op_reg == OP_LOAD) ? od_reg : ad_reg;
                if (op_reg == OP_DIV)
                    my = oa_reg;
                else if (op_reg == OP_LOAD || op_reg == OP_INC)
                    my = 32'd1;
                else
                    my = od_reg;
            end
        endcase
    end

    assign prod = {32'd0, mx} * {32'd0, my};

    // Signs of the two terms and their signed-magnitude sum.
    always_comb
    begin
        s0 = an_reg;
        s1 = on_reg;
        case (op_reg)
            OP_LOAD: s0 = on_reg;
            OP_SUB:  s1 = !on_reg;
            OP_INC:  s1 = 1'b0;
            OP_MUL,
            OP_DIV:  s0 = an_reg ^ on_reg;
            default: s1 = on_reg;
        endcase
        if (s0 == s1)
        begin
            sum_m = p0_reg + p1_reg;
            sum_n = s0;
        end
        else if (p0_reg >= p1_reg)
        begin
            sum_m = p0_reg - p1_reg;
            sum_n = s0;
        end
        else
        begin
            sum_m = p1_reg - p0_reg;
            sum_n = s1;
        end
    end

    assign dn_try = {rmn_reg[62:0], qn_reg[63]};
    assign dd_try = {rmd_reg[62:0], qd_reg[63]};
    assign ovf    = (qn_reg > (rn_reg ? LIM + 64'd1 : LIM)) || (qd_reg > LIM);
    assign s_axis_tready = (state_reg == S_IDLE);

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        store_next     = store_reg;
        acc_num_next   = acc_num_reg;
        acc_den_next   = acc_den_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        am_next        = am_reg;
        ad_next        = ad_reg;
        oa_next        = oa_reg;
        od_next        = od_reg;
        an_next        = an_reg;
        on_next        = on_reg;
        rn_next        = rn_reg;
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        ga_next        = ga_reg;
        gb_next        = gb_reg;
        qn_next        = qn_reg;
        qd_next        = qd_reg;
        rmn_next       = rmn_reg;
        rmd_next       = rmd_reg;
        g_next         = g_reg;
        res_next       = res_reg;
        on_out_next    = on_out_reg;
        od_out_next    = od_out_reg;
        st_out_next    = st_out_reg;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next     = s_axis_tuser;
                    oa_next     = mag_num;
                    od_next     = mag_den;
                    on_next     = in_num[31] ^ in_den[31];
                    an_next     = acc_num_reg[31];
                    am_next     = acc_num_reg[31] ? (32'd0 - acc_num_reg) : acc_num_reg;
                    ad_next     = acc_den_reg;
                    status_next = ST_OK;
                    cnt_next    = '0;
                    if (s_axis_tuser <= OP_DIV && mag_den == 32'd0)
                    begin
                        status_next = ST_ZERO;
                        store_next  = 1'b0;
                        state_next  = S_WB;
                    end
                    else if (s_axis_tuser == OP_DIV && mag_num == 32'd0)
                    begin
                        status_next = ST_ZERO;
                        store_next  = 1'b0;
                        state_next  = S_WB;
                    end
                    else if (s_axis_tuser > OP_INC)
                    begin
                        store_next = 1'b0;
                        state_next = S_WB;
                    end
                    else
                    begin
                        store_next = 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                case (cnt_reg[1:0])
                    2'd0:    p0_next = prod;
                    2'd1:    p1_next = prod;
                    default: p2_next = prod;
                endcase
                if (cnt_reg[1:0] == 2'd2)
                    state_next = S_COMB;
                cnt_next = cnt_reg + 6'd1;
            end
            S_COMB:
            begin
                if (op_reg == OP_ADD || op_reg == OP_SUB || op_reg == OP_INC)
                begin
                    res_next = sum_m;
                    rn_next  = sum_n;
                end
                else
                begin
                    res_next = p0_reg;
                    rn_next  = s0;
                end
                if (res_next == 64'd0)
                begin
                    rn_next    = 1'b0;
                    qn_next    = 64'd0;
                    qd_next    = 64'd1;
                    state_next = S_WB;
                end
                else
                begin
                    ga_next    = res_next;
                    gb_next    = p2_reg;
                    qn_next    = res_next;
                    qd_next    = p2_reg;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                // One binary gcd step; common factors of two come off the dividends too.
                cnt_next = '0;
                if (ga_reg == 64'd0 || gb_reg == 64'd0)
                begin
                    g_next     = ga_reg | gb_reg;
                    rmn_next   = 64'd0;
                    rmd_next   = 64'd0;
                    state_next = S_DIV;
                end
                else if (!ga_reg[0] && !gb_reg[0])
                begin
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                    qn_next = qn_reg >> 1;
                    qd_next = qd_reg >> 1;
                end
                else if (!ga_reg[0])
                    ga_next = ga_reg >> 1;
                else if (!gb_reg[0])
                    gb_next = gb_reg >> 1;
                else if (ga_reg >= gb_reg)
                    ga_next = ga_reg - gb_reg;
                else
                    gb_next = gb_reg - ga_reg;
            end
            S_DIV:
            begin
                // Two restoring divisions by the odd gcd part, one quotient bit each.
                qn_next = {qn_reg[62:0], dn_try >= g_reg};
                qd_next = {qd_reg[62:0], dd_try >= g_reg};
                rmn_next = (dn_try >= g_reg) ? dn_try - g_reg : dn_try;
                rmd_next = (dd_try >= g_reg) ? dd_try - g_reg : dd_try;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = S_WB;
            end
            S_WB:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    if (store_reg && ovf)
                        status_next = ST_OVF;
                    else if (store_reg)
                    begin
                        acc_num_next = rn_reg ? (32'd0 - qn_reg[31:0]) : qn_reg[31:0];
                        acc_den_next = qd_reg[31:0];
                    end
                    on_out_next    = acc_num_next;
                    od_out_next    = acc_den_next[30:0];
                    st_out_next    = status_next;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state and the accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            store_reg     <= 1'b0;
            acc_num_reg   <= 32'd0;
            acc_den_reg   <= 32'd1;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            store_reg     <= store_next;
            acc_num_reg   <= acc_num_next;
            acc_den_reg   <= acc_den_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        status_reg <= status_next;
        am_reg     <= am_next;
        ad_reg     <= ad_next;
        oa_reg     <= oa_next;
        od_reg     <= od_next;
        an_reg     <= an_next;
        on_reg     <= on_next;
        rn_reg     <= rn_next;
        p0_reg     <= p0_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        ga_reg     <= ga_next;
        gb_reg     <= gb_next;
        qn_reg     <= qn_next;
        qd_reg     <= qd_next;
        rmn_reg    <= rmn_next;
        rmd_reg    <= rmd_next;
        g_reg      <= g_next;
        res_reg    <= res_next;
        on_out_reg <= on_out_next;
        od_out_reg <= od_out_next;
        st_out_reg <= st_out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, od_out_reg, on_out_reg};
    assign m_axis_tuser  = st_out_reg;

    // A result beat always carries a nonzero denominator.
    a_out_den: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[62:32] != 31'd0))
        else $error("result denominator is zero");

    // The stored denominator never becomes zero.
    a_acc_den: assert property (@(posedge clk) disable iff (!rst_n)
        acc_den_reg != 32'd0)
        else $error("accumulator denominator is zero");

    // The sequencer holds exactly one state.
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register is not one-hot");

    // An accepted beat leaves idle on the next cycle.
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after an accepted beat");

endmodule
